// ===== sv/adp_pkg.sv =====
// Shared types, codes and layer constants for the atmosphere profile block.
// Used by every module of the block; depends on nothing.
package adp_pkg;

    localparam int ALT_W   = 23;
    localparam int WAVE_W  = 11;
    localparam int DEN_W   = 31;
    localparam int THK_W   = 31;
    localparam int REF_W   = 37;
    localparam int DIST_W  = 40;
    localparam int SEA_W   = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int ITERS   = 12;

    localparam logic [DIST_W-1:0] BASE_MID  = 40'd184869318;
    localparam logic [DIST_W-1:0] BASE_HIGH = 40'd539587311;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [31:0] LN2_Q32  = 32'hB172_17F8;
    localparam logic [30:0] MAX31    = 31'h7FFF_FFFF;

    localparam logic [WAVE_W-1:0] WAVE_MIN   = 11'd200;
    localparam logic [WAVE_W-1:0] WAVE_RESET = 11'd400;
    localparam logic [63:0] SEA_C0 = 64'd76742182075;
    localparam logic [63:0] SEA_C1 = 64'd345876451382054;
    localparam logic [63:0] SEA_C2 = 64'd10006435422063820800;
    localparam logic [29:0] QSCALE_MID  = 30'd318975825;
    localparam logic [29:0] QSCALE_HIGH = 30'd11150260;

    typedef enum logic [1:0] {
        LAYER_LOW,
        LAYER_MID,
        LAYER_HIGH
    } layer_t;

    typedef enum logic [2:0] {
        SEA_IDLE,
        SEA_SQUARE,
        SEA_DIV_C1,
        SEA_DIV_C2,
        SEA_DIV_C3,
        SEA_SCALE
    } sea_state_t;

    typedef struct packed {
        layer_t              layer;
        logic [DIST_W-1:0]   span;
    } qitem_t;

    typedef struct packed {
        logic [SEA_W-1:0] sq0;
        logic [SEA_W-1:0] sq1;
        logic [SEA_W-1:0] sq2;
    } refr_scale_t;

    typedef struct packed {
        layer_t     layer;
        logic       dead;
        logic [5:0] sh;
    } side_t;

    function automatic logic [21:0] layer_rate(input layer_t l);
        case (l)
            LAYER_LOW:  layer_rate = 22'd2666200;
            LAYER_MID:  layer_rate = 22'd3839275;
            LAYER_HIGH: layer_rate = 22'd3267722;
            default:    layer_rate = 22'd0;
        endcase
    endfunction

    function automatic logic [30:0] layer_rho(input layer_t l);
        case (l)
            LAYER_LOW:  layer_rho = 31'd1346901744;
            LAYER_MID:  layer_rho = 31'd400123276;
            LAYER_HIGH: layer_rho = 31'd13986887;
            default:    layer_rho = 31'd0;
        endcase
    endfunction

    function automatic logic [19:0] layer_g(input layer_t l);
        case (l)
            LAYER_LOW:  layer_g = 20'd907824;
            LAYER_MID:  layer_g = 20'd630442;
            LAYER_HIGH: layer_g = 20'd740712;
            default:    layer_g = 20'd0;
        endcase
    endfunction

    function automatic logic signed [32:0] layer_h(input layer_t l);
        case (l)
            LAYER_LOW:  layer_h = -33'sd104374562;
            LAYER_MID:  layer_h = 33'sd1470884;
            LAYER_HIGH: layer_h = 33'sd0;
            default:    layer_h = 33'sd0;
        endcase
    endfunction

    // floor(2^32 / n)
    function automatic logic [31:0] recip32(input logic [3:0] n);
        case (n)
            4'd2:    recip32 = 32'd2147483648;
            4'd3:    recip32 = 32'd1431655765;
            4'd4:    recip32 = 32'd1073741824;
            4'd5:    recip32 = 32'd858993459;
            4'd6:    recip32 = 32'd715827882;
            4'd7:    recip32 = 32'd613566756;
            4'd8:    recip32 = 32'd536870912;
            4'd9:    recip32 = 32'd477218588;
            4'd10:   recip32 = 32'd429496729;
            4'd11:   recip32 = 32'd390451572;
            4'd12:   recip32 = 32'd357913941;
            default: recip32 = 32'hFFFF_FFFF;
        endcase
    endfunction

endpackage

// ===== sv/adp_queue.sv =====
// Short queue between the classifying front and the compute pipeline.
// Depends on adp_pkg.
module adp_queue
    import adp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qitem_t push_item,
    input  logic   pop,
    output qitem_t head,
    output logic   empty,
    output logic   full
);

    qitem_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_item;
        end
    end

    assign head  = mem[rptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

// ===== sv/adp_front.sv =====
// Input side: takes altitude transactions, picks the layer and the distance
// above the layer base. Depends on adp_pkg.
module adp_front
    import adp_pkg::*;
#(
    parameter int ALT_FRAC_BITS = 16
)
(
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ALT_W-1:0] altitude_q16,
    input  logic             busy,
    input  logic             full,
    output logic             push,
    output qitem_t           item
);

    localparam int SHIFT = 24 - ALT_FRAC_BITS;

    logic [DIST_W-1:0] alt_q24;

    always_comb
    begin
        alt_q24 = DIST_W'(altitude_q16) << SHIFT;
        if (alt_q24 < BASE_MID)
        begin
            item.layer = LAYER_LOW;
            item.span  = alt_q24;
        end
        else if (alt_q24 < BASE_HIGH)
        begin
            item.layer = LAYER_MID;
            item.span  = alt_q24 - BASE_MID;
        end
        else
        begin
            item.layer = LAYER_HIGH;
            item.span  = alt_q24 - BASE_HIGH;
        end
    end

    assign in_ready = !full && !busy;
    assign push     = in_valid && in_ready;

endmodule

// ===== sv/adp_sea.sv =====
// Sea-level refractivity unit: wavelength register, serial divider and
// serial per-layer scaling, rerun after reset and each write. Depends on adp_pkg.
module adp_sea
    import adp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [WAVE_W-1:0] cfg_data,
    output logic              busy,
    output refr_scale_t       scale
);

    sea_state_t        state_reg, state_next;
    logic [WAVE_W-1:0] wave_reg;
    logic [21:0]       l2_reg;
    logic [63:0]       dq_reg;
    logic [21:0]       rem_reg;
    logic [63:0]       acc_reg;
    logic [SEA_W-1:0]  sea_reg;
    logic [69:0]       m1_reg;
    logic [69:0]       m2_reg;
    logic [5:0]        cnt_reg;

    logic [WAVE_W-1:0] wave_eff;
    logic [21:0]       wave_sq;
    logic [22:0]       rem_sh;
    logic [22:0]       rem_sub;
    logic              ge;
    logic [21:0]       rem_step;
    logic [63:0]       dq_step;
    logic              cnt_zero;

    always_comb
    begin
        wave_eff = (wave_reg < WAVE_MIN) ? WAVE_MIN : wave_reg;
        wave_sq  = 22'(wave_eff) * 22'(wave_eff);
        rem_sh   = {rem_reg, dq_reg[63]};
        rem_sub  = rem_sh - {1'b0, l2_reg};
        ge       = (rem_sh >= {1'b0, l2_reg});
        rem_step = ge ? rem_sub[21:0] : rem_sh[21:0];
        dq_step  = {dq_reg[62:0], ge};
        cnt_zero = (cnt_reg == '0);
    end

    always_comb
    begin
        case (state_reg)
            SEA_IDLE:   state_next = SEA_IDLE;
            SEA_SQUARE: state_next = SEA_DIV_C1;
            SEA_DIV_C1: state_next = cnt_zero ? SEA_DIV_C2 : SEA_DIV_C1;
            SEA_DIV_C2: state_next = cnt_zero ? SEA_DIV_C3 : SEA_DIV_C2;
            SEA_DIV_C3: state_next = cnt_zero ? SEA_SCALE : SEA_DIV_C3;
            SEA_SCALE:  state_next = cnt_zero ? SEA_IDLE : SEA_SCALE;
            default:    state_next = SEA_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = SEA_SQUARE;
        end
    end

    always_comb
    begin
        busy      = (state_reg != SEA_IDLE);
        scale.sq0 = sea_reg;
        scale.sq1 = m1_reg[69:30];
        scale.sq2 = m2_reg[69:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEA_SQUARE;
            wave_reg  <= WAVE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                wave_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SEA_SQUARE:
            begin
                l2_reg  <= wave_sq;
                dq_reg  <= SEA_C1;
                rem_reg <= '0;
                cnt_reg <= 6'd63;
            end
            SEA_DIV_C1:
            begin
                dq_reg  <= dq_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    acc_reg <= SEA_C0 + dq_step;
                    dq_reg  <= SEA_C2;
                    rem_reg <= '0;
                    cnt_reg <= 6'd63;
                end
            end
            SEA_DIV_C2:
            begin
                dq_reg  <= dq_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    rem_reg <= '0;
                    cnt_reg <= 6'd63;
                end
            end
            SEA_DIV_C3:
            begin
                dq_reg  <= dq_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    sea_reg <= acc_reg[SEA_W-1:0] + dq_step[SEA_W-1:0];
                    m1_reg  <= '0;
                    m2_reg  <= '0;
                    cnt_reg <= 6'd29;
                end
            end
            SEA_SCALE:
            begin
                m1_reg  <= {m1_reg[68:0], 1'b0}
                           + (QSCALE_MID[cnt_reg[4:0]] ? 70'(sea_reg) : 70'd0);
                m2_reg  <= {m2_reg[68:0], 1'b0}
                           + (QSCALE_HIGH[cnt_reg[4:0]] ? 70'(sea_reg) : 70'd0);
                cnt_reg <= cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

// ===== sv/adp_back.sv =====
// Compute pipeline: exponent, 2^-f series in twelve three-stage steps,
// density, refractivity and thickness, output register. Depends on adp_pkg.
module adp_back
    import adp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  qitem_t            head,
    input  logic              empty,
    output logic              pop,
    input  refr_scale_t       scale,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        layer_index,
    output logic [DEN_W-1:0]  density_scaled,
    output logic [THK_W-1:0]  thickness_scaled,
    output logic [REF_W-1:0]  refractivity_scaled
);

    logic en;

    // front stages
    logic              v0_reg, v1_reg, v2_reg, v3_reg;
    layer_t            lay0_reg, lay1_reg;
    logic [DIST_W-1:0] d0_reg;
    logic [41:0]       eh1_reg, el1_reg;
    side_t             s2_reg, s3_reg;
    logic [31:0]       f2_reg;
    logic [29:0]       x3_reg;

    logic [21:0]       rate0;
    logic [61:0]       e_sum;
    logic [63:0]       xf;

    // series steps
    logic        av_reg [ITERS];
    logic [29:0] ax_reg [ITERS];
    logic [29:0] ap_reg [ITERS];
    side_t       as_reg [ITERS];
    logic        bv_reg [ITERS];
    logic [29:0] bx_reg [ITERS];
    logic [29:0] bp_reg [ITERS];
    logic [29:0] bq_reg [ITERS];
    side_t       bs_reg [ITERS];
    logic        cv_reg [ITERS];
    logic [29:0] cx_reg [ITERS];
    logic [30:0] ct_reg [ITERS];
    side_t       cs_reg [ITERS];

    // tail stages
    logic        v5_reg, v6_reg, v7_reg, v8_reg;
    side_t       s5_reg;
    layer_t      lay6_reg, lay7_reg, lay8_reg;
    logic [61:0] dp5_reg;
    logic [50:0] rh5_reg, rl5_reg;
    logic [30:0] rho6_reg, rho7_reg, rho8_reg;
    logic [36:0] ref6_reg, ref7_reg, ref8_reg;
    logic [50:0] tp7_reg;
    logic [30:0] th8_reg;

    side_t            s_last;
    logic [30:0]      m_last;
    logic [SEA_W-1:0] sq_sel;
    logic [51:0]      inner;
    logic [41:0]      mulv;
    logic [41:0]      ref_sh;
    logic [31:0]      rho_sh;
    logic signed [32:0] th_sum;

    assign en  = !v8_reg || out_ready;
    assign pop = en && !empty;

    always_comb
    begin
        rate0 = layer_rate(lay0_reg);
        e_sum = {eh1_reg, 20'd0} + 62'(el1_reg);
        xf    = f2_reg * LN2_Q32;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= !empty;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lay0_reg     <= head.layer;
            d0_reg       <= head.span;
            eh1_reg      <= d0_reg[39:20] * rate0;
            el1_reg      <= d0_reg[19:0] * rate0;
            lay1_reg     <= lay0_reg;
            s2_reg.layer <= lay1_reg;
            s2_reg.dead  <= (e_sum[61:48] >= 14'd40);
            s2_reg.sh    <= e_sum[53:48];
            f2_reg       <= e_sum[47:16];
            s3_reg       <= s2_reg;
            x3_reg       <= xf[63:34];
        end
    end

    for (genvar j = 0; j < ITERS; j++)
    begin : g_step
        localparam int N = ITERS - j;

        logic        v_in;
        logic [29:0] x_in;
        logic [30:0] t_in;
        side_t       s_in;
        logic [60:0] xt;
        logic [61:0] qm;
        logic [29:0] q0;
        logic [33:0] r;
        logic [29:0] q;

        if (j == 0)
        begin : g_first
            assign v_in = v3_reg;
            assign x_in = x3_reg;
            assign t_in = Q30_ONE;
            assign s_in = s3_reg;
        end
        else
        begin : g_next
            assign v_in = cv_reg[j-1];
            assign x_in = cx_reg[j-1];
            assign t_in = ct_reg[j-1];
            assign s_in = cs_reg[j-1];
        end

        always_comb
        begin
            xt = x_in * t_in;
            qm = ap_reg[j] * recip32(4'(N));
            q0 = (N == 1) ? ap_reg[j] : qm[61:32];
            r  = 34'(bp_reg[j]) - 34'(bq_reg[j]) * 34'(N);
            q  = bq_reg[j] + 30'(r >= 34'(N));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                av_reg[j] <= 1'b0;
                bv_reg[j] <= 1'b0;
                cv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                av_reg[j] <= v_in;
                bv_reg[j] <= av_reg[j];
                cv_reg[j] <= bv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ax_reg[j] <= x_in;
                ap_reg[j] <= xt[59:30];
                as_reg[j] <= s_in;
                bx_reg[j] <= ax_reg[j];
                bp_reg[j] <= ap_reg[j];
                bq_reg[j] <= q0;
                bs_reg[j] <= as_reg[j];
                cx_reg[j] <= bx_reg[j];
                ct_reg[j] <= Q30_ONE - 31'(q);
                cs_reg[j] <= bs_reg[j];
            end
        end
    end

    always_comb
    begin
        s_last = cs_reg[ITERS-1];
        m_last = ct_reg[ITERS-1];
        case (s_last.layer)
            LAYER_LOW:  sq_sel = scale.sq0;
            LAYER_MID:  sq_sel = scale.sq1;
            LAYER_HIGH: sq_sel = scale.sq2;
            default:    sq_sel = '0;
        endcase
        inner  = 52'({rh5_reg[9:0], 20'd0}) + 52'(rl5_reg);
        mulv   = 42'(rh5_reg[50:10]) + 42'(inner[51:30]);
        ref_sh = mulv >> s5_reg.sh;
        rho_sh = dp5_reg[61:30] >> s5_reg.sh;
        th_sum = $signed({2'b00, tp7_reg[50:20]}) + layer_h(lay7_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= cv_reg[ITERS-1];
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg  <= s_last;
            dp5_reg <= layer_rho(s_last.layer) * m_last;
            rh5_reg <= sq_sel[39:20] * m_last;
            rl5_reg <= sq_sel[19:0] * m_last;

            lay6_reg <= s5_reg.layer;
            if (s5_reg.dead)
            begin
                rho6_reg <= '0;
                ref6_reg <= '0;
            end
            else
            begin
                rho6_reg <= rho_sh[31] ? MAX31 : rho_sh[30:0];
                ref6_reg <= (ref_sh[41:37] != 5'd0) ? '1 : ref_sh[36:0];
            end

            lay7_reg <= lay6_reg;
            rho7_reg <= rho6_reg;
            ref7_reg <= ref6_reg;
            tp7_reg  <= layer_g(lay6_reg) * rho6_reg;

            lay8_reg <= lay7_reg;
            rho8_reg <= rho7_reg;
            ref8_reg <= ref7_reg;
            if (th_sum < 0)
            begin
                th8_reg <= '0;
            end
            else if (th_sum > $signed({2'b00, MAX31}))
            begin
                th8_reg <= MAX31;
            end
            else
            begin
                th8_reg <= th_sum[30:0];
            end
        end
    end

    assign out_valid           = v8_reg;
    assign layer_index         = lay8_reg;
    assign density_scaled      = rho8_reg;
    assign thickness_scaled    = th8_reg;
    assign refractivity_scaled = ref8_reg;

endmodule

// ===== sv/atmosphere_density_depth_profile_unit.sv =====
// Top level of the piecewise exponential atmosphere profile block.
// Depends on adp_pkg, adp_front, adp_queue, adp_back and adp_sea.
//
// Input channel: in_valid/in_ready carry altitude_q16 (km, ALT_FRAC_BITS
// fraction bits). Output channel: out_valid/out_ready carry layer_index,
// density_scaled, thickness_scaled and refractivity_scaled, one result per
// input transaction, in order.
// Throughput: one transaction per cycle outside recomputes and output
// stalls, set by the fully pipelined compute path (twelve three-stage
// steps of the 2^-f series).
// cfg_we/cfg_data write the wavelength in nm. Each write, and reset, starts
// a serial recompute of the sea-level refractivity (three 64-step divisions
// and a 30-step scaling); in_ready is low during that time.
// Reset: wavelength 400 nm, pipeline and queue empty.
// Output stall: the compute pipeline holds while a result waits; a 4-entry
// queue keeps taking input transactions until it fills.
module atmosphere_density_depth_profile_unit
    import adp_pkg::*;
#(
    parameter int ALT_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ALT_W-1:0]  altitude_q16,
    input  logic              cfg_we,
    input  logic [WAVE_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        layer_index,
    output logic [DEN_W-1:0]  density_scaled,
    output logic [THK_W-1:0]  thickness_scaled,
    output logic [REF_W-1:0]  refractivity_scaled
);

    logic        busy;
    logic        full;
    logic        empty;
    logic        push;
    logic        pop;
    qitem_t      push_item;
    qitem_t      head;
    refr_scale_t scale;

    adp_front #(
        .ALT_FRAC_BITS (ALT_FRAC_BITS)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .altitude_q16 (altitude_q16),
        .busy         (busy),
        .full         (full),
        .push         (push),
        .item         (push_item)
    );

    adp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    adp_sea u_sea (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .busy     (busy),
        .scale    (scale)
    );

    adp_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head                (head),
        .empty               (empty),
        .pop                 (pop),
        .scale               (scale),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .layer_index         (layer_index),
        .density_scaled      (density_scaled),
        .thickness_scaled    (thickness_scaled),
        .refractivity_scaled (refractivity_scaled)
    );

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input taken during refractivity recompute");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue overflow");

    a_layer_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (layer_index != 2'd3))
        else $error("bad layer on output");

endmodule

// ===== tb/adp_checker.sv =====
// Checker for the atmosphere profile block: predicts each result from the
// accepted altitude and the current wavelength, and compares in order.
// Depends on adp_pkg.
module adp_checker
    import adp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [ALT_W-1:0]  altitude_q16,
    input  logic              cfg_we,
    input  logic [WAVE_W-1:0] cfg_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        layer_index,
    input  logic [DEN_W-1:0]  density_scaled,
    input  logic [THK_W-1:0]  thickness_scaled,
    input  logic [REF_W-1:0]  refractivity_scaled,
    output int                errors,
    output int                pending
);

    typedef struct {
        layer_t          layer;
        bit [DEN_W-1:0]  density;
        bit [THK_W-1:0]  thickness;
        bit [REF_W-1:0]  refr;
    } profile_t;

    profile_t        profile_q[$];
    bit [SEA_W-1:0]  sea_refr;

    function automatic bit [SEA_W-1:0] sea_for_wave(input bit [WAVE_W-1:0] wave);
        bit [63:0] l;
        bit [63:0] l2;
        bit [63:0] c1;
        bit [63:0] c2;
        l = (wave < 200) ? 64'd200 : 64'(wave);
        l2 = l * l;
        c1 = (64'd1 << 48) * 64'd768 / 64'd625;
        c2 = (64'd1 << 48) * 64'd35550;
        return SEA_W'(64'd76742182075 + c1 / l2 + (c2 / l2) / l2);
    endfunction

    function automatic bit [63:0] fix_mul30(input bit [63:0] x, input bit [63:0] y);
        bit [127:0] p;
        p = 128'(x) * 128'(y);
        return 64'(p >> 30);
    endfunction

    function automatic profile_t predict_profile(input bit [ALT_W-1:0] alt);
        profile_t  r;
        bit [63:0] a, d, e, ip, f, x, t, m, rho, refr, q, base, rate, rr, g;
        longint    h1, d0, h, th;
        a = 64'(alt) << 8;
        if (a < 64'd184869318) begin
            r.layer = LAYER_LOW;  base = 0;          rate = 2666200; rr = 1346901744; g = 907824;
        end else if (a < 64'd539587311) begin
            r.layer = LAYER_MID;  base = 184869318;  rate = 3839275; rr = 400123276;  g = 630442;
        end else begin
            r.layer = LAYER_HIGH; base = 539587311;  rate = 3267722; rr = 13986887;   g = 740712;
        end
        d = a - base;
        e = (d * rate) >> 16;
        ip = e >> 32;
        f = e & 64'hFFFF_FFFF;
        x = (f * 64'hB172_17F8) >> 34;
        t = 64'd1 << 30;
        for (int n = 12; n >= 1; n--)
            t = (64'd1 << 30) - ((x * t) >> 30) / 64'(n);
        m = t;
        rho = 0;
        refr = 0;
        if (ip < 40) begin
            q = (rr << 30) / 64'd1346901744;
            rho = ((rr * m) >> 30) >> ip;
            refr = fix_mul30(fix_mul30(64'(sea_refr), q), m) >> ip;
        end
        if (rho > 64'h7FFF_FFFF) rho = 64'h7FFF_FFFF;
        if (refr > ((64'd1 << 37) - 1)) refr = (64'd1 << 37) - 1;
        h1 = longint'((64'd13986887 * (64'd740712 - 64'd630442)) >> 20);
        d0 = longint'((64'd400123276 * (64'd907824 - 64'd630442)) >> 20);
        h = (r.layer == LAYER_HIGH) ? 0 : (r.layer == LAYER_MID) ? h1 : h1 - d0;
        th = longint'((g * rho) >> 20) + h;
        if (th < 0) th = 0;
        if (th > 64'h7FFF_FFFF) th = 64'h7FFF_FFFF;
        r.density = rho[DEN_W-1:0];
        r.thickness = th[THK_W-1:0];
        r.refr = refr[REF_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        profile_t exp_p;
        if (!rst_n)
        begin
            profile_q.delete();
            sea_refr = sea_for_wave(11'd400);
            errors = 0;
        end
        else
        begin
            if (cfg_we)
                sea_refr = sea_for_wave(cfg_data);
            if (in_valid && in_ready)
                profile_q = {profile_q, predict_profile(altitude_q16)};
            if (out_valid && out_ready)
            begin
                if (profile_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction on output");
                end
                else
                begin
                    exp_p = profile_q.pop_front();
                    if (layer_index !== exp_p.layer || density_scaled !== exp_p.density ||
                        thickness_scaled !== exp_p.thickness ||
                        refractivity_scaled !== exp_p.refr)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     exp_p.layer, exp_p.density, exp_p.thickness, exp_p.refr,
                                     layer_index, density_scaled, thickness_scaled,
                                     refractivity_scaled);
                    end
                end
            end
        end
        pending = profile_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the atmosphere profile block: drives altitudes and
// wavelength writes, idles both channels, reports the verdict.
// Depends on adp_pkg, adp_checker and the block's RTL.
module tb_top;
    import adp_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [ALT_W-1:0]  altitude_q16;
    logic              cfg_we;
    logic [WAVE_W-1:0] cfg_data;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        layer_index;
    logic [DEN_W-1:0]  density_scaled;
    logic [THK_W-1:0]  thickness_scaled;
    logic [REF_W-1:0]  refractivity_scaled;
    int                errors;
    int                pending;
    int                idle_cycles;
    bit                no_gaps;

    atmosphere_density_depth_profile_unit dut (.*);

    adp_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    int stall_left;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_altitude(input bit [ALT_W-1:0] alt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        altitude_q16 <= alt;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_wavelength(input bit [WAVE_W-1:0] wave);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= wave;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic bit [ALT_W-1:0] random_altitude();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return ALT_W'($urandom_range(0, 100 * 65536));
        if (r < 7) return ALT_W'($urandom_range(715000, 730000));
        if (r < 8) return ALT_W'($urandom_range(2100000, 2115000));
        return ALT_W'($urandom);
    endfunction

    bit [WAVE_W-1:0] waves [8] = '{11'd0, 11'd199, 11'd200, 11'd2000, 11'd2047,
                                   11'd650, 11'd1024, 11'd400};
    bit [ALT_W-1:0]  directed [12] = '{23'd0, 23'd1, 23'd722145, 23'd722146,
                                       23'd722147, 23'd2107762, 23'd2107763,
                                       23'd2107764, 23'd3503000, 23'h7FFFFF,
                                       23'h555555, 23'h2AAAAA};

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        altitude_q16 = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        no_gaps = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed[i])
            send_altitude(directed[i]);
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph > 0)
            begin
                write_wavelength(ph == 8 ? 11'($urandom_range(200, 2000)) : waves[ph - 1]);
                foreach (directed[i])
                    send_altitude(directed[i]);
            end
            no_gaps = (ph % 3 == 2);
            repeat (160)
                send_altitude(random_altitude());
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
